### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/pmcr_pkg.sv
// ---------------------------------------------------------------------------
// Pair momentum cut and rotate package
// Widths, constants, register map and beat types shared by the block.
// ---------------------------------------------------------------------------
package pmcr_pkg;

    localparam int MOMENTUM_WIDTH = 24;
    localparam int CORDIC_STEPS   = 24;
    localparam int EVENT_WIDTH    = 24;
    localparam int COUNT_WIDTH    = 24;
    localparam int LIMIT_WIDTH    = 23;
    localparam int KEEP_WIDTH     = 24;
    localparam int GUARD_SHIFT    = 6;
    localparam int CORDIC_WIDTH   = MOMENTUM_WIDTH + GUARD_SHIFT + 4;
    localparam int STEP_WIDTH     = $clog2(CORDIC_STEPS);
    localparam int GAIN_WIDTH     = 25;
    localparam int FINAL_SHIFT    = 30;
    localparam int PROD_WIDTH     = CORDIC_WIDTH + GAIN_WIDTH;
    localparam int ROUND_WIDTH    = PROD_WIDTH - FINAL_SHIFT;
    localparam logic signed [GAIN_WIDTH-1:0] INV_GAIN_Q24 = 25'sd10188014;

    localparam int ADDR_WIDTH = 5;
    localparam int DATA_WIDTH = 32;
    localparam int REG_IDX_WIDTH = 3;

    localparam logic [REG_IDX_WIDTH-1:0] REG_POLARIZATION_AXIS = 3'd0;
    localparam logic [REG_IDX_WIDTH-1:0] REG_CUT_ENABLE        = 3'd1;
    localparam logic [REG_IDX_WIDTH-1:0] REG_Y_AXIS_LIMIT      = 3'd2;
    localparam logic [REG_IDX_WIDTH-1:0] REG_Z_AXIS_LIMIT      = 3'd3;
    localparam logic [REG_IDX_WIDTH-1:0] REG_ROTATE_FOR_Y      = 3'd4;
    localparam logic [REG_IDX_WIDTH-1:0] REG_ROTATE_FOR_Z      = 3'd5;
    localparam logic [REG_IDX_WIDTH-1:0] REG_LIMIT_ENABLE      = 3'd6;
    localparam logic [REG_IDX_WIDTH-1:0] REG_KEEP_LIMIT        = 3'd7;

    typedef enum logic [1:0] {
        ST_WRITTEN = 2'd0,
        ST_CUT     = 2'd1,
        ST_LIMIT   = 2'd2
    } status_t;

    typedef struct packed {
        logic                             polarization_axis;
        logic                             cut_enable;
        logic [LIMIT_WIDTH-1:0]           y_axis_limit;
        logic [LIMIT_WIDTH-1:0]           z_axis_limit;
        logic                             rotate_for_y;
        logic                             rotate_for_z;
        logic                             limit_enable;
        logic [KEEP_WIDTH-1:0]            keep_limit;
    } cfg_t;

    typedef struct packed {
        logic                             new_file;
        logic [EVENT_WIDTH-1:0]           event_number;
        logic signed [MOMENTUM_WIDTH-1:0] proton_px;
        logic signed [MOMENTUM_WIDTH-1:0] proton_py;
        logic signed [MOMENTUM_WIDTH-1:0] proton_pz;
        logic signed [MOMENTUM_WIDTH-1:0] neutron_px;
        logic signed [MOMENTUM_WIDTH-1:0] neutron_py;
        logic signed [MOMENTUM_WIDTH-1:0] neutron_pz;
    } pair_t;

    typedef struct packed {
        status_t                          status;
        logic                             was_rotated;
        logic [EVENT_WIDTH-1:0]           out_event_number;
        logic signed [MOMENTUM_WIDTH-1:0] out_proton_px;
        logic signed [MOMENTUM_WIDTH-1:0] out_proton_py;
        logic signed [MOMENTUM_WIDTH-1:0] out_proton_pz;
        logic signed [MOMENTUM_WIDTH-1:0] out_neutron_px;
        logic signed [MOMENTUM_WIDTH-1:0] out_neutron_py;
        logic signed [MOMENTUM_WIDTH-1:0] out_neutron_pz;
    } result_t;

    typedef struct packed {
        logic                             negate;
        logic signed [MOMENTUM_WIDTH:0]   sum_x;
        logic signed [MOMENTUM_WIDTH:0]   sum_y;
        logic signed [MOMENTUM_WIDTH-1:0] proton_px;
        logic signed [MOMENTUM_WIDTH-1:0] proton_py;
        logic signed [MOMENTUM_WIDTH-1:0] neutron_px;
        logic signed [MOMENTUM_WIDTH-1:0] neutron_py;
    } cordic_load_t;

    typedef struct packed {
        logic signed [CORDIC_WIDTH-1:0]   proton_px;
        logic signed [CORDIC_WIDTH-1:0]   proton_py;
        logic signed [CORDIC_WIDTH-1:0]   neutron_px;
        logic signed [CORDIC_WIDTH-1:0]   neutron_py;
    } cordic_vec_t;

endpackage

### hw/rtl/pmcr_regs.sv
// ---------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the cut, rotation and keep-limit settings.
// ---------------------------------------------------------------------------
module pmcr_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pmcr_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [pmcr_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [pmcr_pkg::DATA_WIDTH-1:0] prdata,
    output logic                            pready,
    output pmcr_pkg::cfg_t                  cfg
);
    import pmcr_pkg::*;

    cfg_t                     cfg_reg;
    cfg_t                     cfg_next;
    logic [REG_IDX_WIDTH-1:0] reg_idx;
    logic                     wr_en;

    assign reg_idx = paddr[ADDR_WIDTH-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_POLARIZATION_AXIS: cfg_next.polarization_axis = pwdata[0];
                REG_CUT_ENABLE:        cfg_next.cut_enable        = pwdata[0];
                REG_Y_AXIS_LIMIT:      cfg_next.y_axis_limit      = pwdata[LIMIT_WIDTH-1:0];
                REG_Z_AXIS_LIMIT:      cfg_next.z_axis_limit      = pwdata[LIMIT_WIDTH-1:0];
                REG_ROTATE_FOR_Y:      cfg_next.rotate_for_y      = pwdata[0];
                REG_ROTATE_FOR_Z:      cfg_next.rotate_for_z      = pwdata[0];
                REG_LIMIT_ENABLE:      cfg_next.limit_enable      = pwdata[0];
                REG_KEEP_LIMIT:        cfg_next.keep_limit        = pwdata[KEEP_WIDTH-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_POLARIZATION_AXIS: prdata = DATA_WIDTH'(cfg_reg.polarization_axis);
            REG_CUT_ENABLE:        prdata = DATA_WIDTH'(cfg_reg.cut_enable);
            REG_Y_AXIS_LIMIT:      prdata = DATA_WIDTH'(cfg_reg.y_axis_limit);
            REG_Z_AXIS_LIMIT:      prdata = DATA_WIDTH'(cfg_reg.z_axis_limit);
            REG_ROTATE_FOR_Y:      prdata = DATA_WIDTH'(cfg_reg.rotate_for_y);
            REG_ROTATE_FOR_Z:      prdata = DATA_WIDTH'(cfg_reg.rotate_for_z);
            REG_LIMIT_ENABLE:      prdata = DATA_WIDTH'(cfg_reg.limit_enable);
            REG_KEEP_LIMIT:        prdata = DATA_WIDTH'(cfg_reg.keep_limit);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.polarization_axis <= 1'b0;
            cfg_reg.cut_enable        <= 1'b1;
            cfg_reg.y_axis_limit      <= LIMIT_WIDTH'(2400);
            cfg_reg.z_axis_limit      <= LIMIT_WIDTH'(2400);
            cfg_reg.rotate_for_y      <= 1'b0;
            cfg_reg.rotate_for_z      <= 1'b1;
            cfg_reg.limit_enable      <= 1'b0;
            cfg_reg.keep_limit        <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hw/rtl/pmcr_cordic.sv
// ---------------------------------------------------------------------------
// Iterative CORDIC vectoring unit
// One micro-rotation per cycle on the sum, proton and neutron vectors,
// steered by the sign of the rotated sum's y.
// ---------------------------------------------------------------------------
module pmcr_cordic (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  pmcr_pkg::cordic_load_t load,
    output logic                   done,
    output pmcr_pkg::cordic_vec_t  vec
);
    import pmcr_pkg::*;

    localparam int LANES = 3;

    logic signed [CORDIC_WIDTH-1:0] vx_reg  [LANES];
    logic signed [CORDIC_WIDTH-1:0] vy_reg  [LANES];
    logic signed [CORDIC_WIDTH-1:0] vx_next [LANES];
    logic signed [CORDIC_WIDTH-1:0] vy_next [LANES];
    logic signed [CORDIC_WIDTH-1:0] vx_load [LANES];
    logic signed [CORDIC_WIDTH-1:0] vy_load [LANES];
    logic [STEP_WIDTH-1:0]          step_reg;
    logic                           busy_reg;
    logic                           last_step;
    logic                           rot_up;

    function automatic logic signed [CORDIC_WIDTH-1:0] scale_in(
        logic signed [MOMENTUM_WIDTH:0] v,
        logic                           neg
    );
        logic signed [CORDIC_WIDTH-1:0] t;
        t = CORDIC_WIDTH'(v) <<< GUARD_SHIFT;
        return neg ? -t : t;
    endfunction

    assign last_step = (step_reg == STEP_WIDTH'(CORDIC_STEPS - 1));
    assign done      = busy_reg && last_step;
    assign rot_up    = vy_reg[0] < 0;

    assign vx_load[0] = scale_in(load.sum_x, load.negate);
    assign vy_load[0] = scale_in(load.sum_y, load.negate);
    assign vx_load[1] = scale_in((MOMENTUM_WIDTH+1)'(load.proton_px), load.negate);
    assign vy_load[1] = scale_in((MOMENTUM_WIDTH+1)'(load.proton_py), load.negate);
    assign vx_load[2] = scale_in((MOMENTUM_WIDTH+1)'(load.neutron_px), load.negate);
    assign vy_load[2] = scale_in((MOMENTUM_WIDTH+1)'(load.neutron_py), load.negate);

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (rot_up)
            begin
                vx_next[i] = vx_reg[i] - (vy_reg[i] >>> step_reg);
                vy_next[i] = vy_reg[i] + (vx_reg[i] >>> step_reg);
            end
            else
            begin
                vx_next[i] = vx_reg[i] + (vy_reg[i] >>> step_reg);
                vy_next[i] = vy_reg[i] - (vx_reg[i] >>> step_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (start)
            begin
                vx_reg[i] <= vx_load[i];
                vy_reg[i] <= vy_load[i];
            end
            else if (busy_reg)
            begin
                vx_reg[i] <= vx_next[i];
                vy_reg[i] <= vy_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= !last_step;
            step_reg <= step_reg + 1'b1;
        end
    end

    assign vec.proton_px  = vx_reg[1];
    assign vec.proton_py  = vy_reg[1];
    assign vec.neutron_px = vx_reg[2];
    assign vec.neutron_py = vy_reg[2];

endmodule

### hw/rtl/pmcr_scale.sv
// ---------------------------------------------------------------------------
// Gain correction and saturation
// Shared multiplier by the inverse CORDIC gain, rounding and clamping to
// the momentum range; one operand per cycle, with the product registered before rounding and clamping.
// ---------------------------------------------------------------------------
module pmcr_scale (
    input  logic                                     clk,
    input  logic signed [pmcr_pkg::CORDIC_WIDTH-1:0] operand,
    output logic signed [pmcr_pkg::MOMENTUM_WIDTH-1:0] scaled
);
    import pmcr_pkg::*;

    localparam logic signed [PROD_WIDTH-1:0] ROUND_BIAS =
        PROD_WIDTH'(1) <<< (FINAL_SHIFT - 1);
    localparam logic signed [ROUND_WIDTH-1:0] SAT_HI =
        {{(ROUND_WIDTH-MOMENTUM_WIDTH+1){1'b0}}, {(MOMENTUM_WIDTH-1){1'b1}}};
    localparam logic signed [ROUND_WIDTH-1:0] SAT_LO =
        {{(ROUND_WIDTH-MOMENTUM_WIDTH+1){1'b1}}, {(MOMENTUM_WIDTH-1){1'b0}}};

    logic signed [PROD_WIDTH-1:0]  prod_reg;
    logic signed [PROD_WIDTH-1:0]  biased;
    logic signed [ROUND_WIDTH-1:0] rounded;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_WIDTH'(operand) * PROD_WIDTH'(INV_GAIN_Q24);
    end

    assign biased  = prod_reg + ROUND_BIAS;
    assign rounded = $signed(biased[PROD_WIDTH-1:FINAL_SHIFT]);

    always_comb
    begin
        if (rounded > SAT_HI)
            scaled = SAT_HI[MOMENTUM_WIDTH-1:0];
        else if (rounded < SAT_LO)
            scaled = SAT_LO[MOMENTUM_WIDTH-1:0];
        else
            scaled = rounded[MOMENTUM_WIDTH-1:0];
    end

endmodule

### hw/rtl/pair_momentum_cut_and_rotate.sv
// ---------------------------------------------------------------------------
// Pair momentum cut and rotate
// Selects proton-neutron events by keep limit and axis cut, and turns the
// transverse momenta of kept events, when rotation is enabled for the chosen axis, so that their sum lies on +x.
// ---------------------------------------------------------------------------
// One event beat is taken at a time. An event that is beyond the keep limit,
// removed by the cut, or not rotated passes from setup straight to done; a
// rotated event also goes through the iterative CORDIC unit, doing one
// micro-rotation a cycle, and the shared gain multiplier, handling the four
// rotated components one after another. The result sits in an output
// register, so the next event is taken while a finished result waits to be
// collected.
module pair_momentum_cut_and_rotate (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pmcr_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [pmcr_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [pmcr_pkg::DATA_WIDTH-1:0] prdata,
    output logic                            pready,
    input  logic                            pair_valid,
    output logic                            pair_stall,
    input  pmcr_pkg::pair_t                 pair_data,
    output logic                            result_valid,
    input  logic                            result_stall,
    output pmcr_pkg::result_t               result_data
);
    import pmcr_pkg::*;

    localparam int SUM_WIDTH = MOMENTUM_WIDTH + 1;
    localparam int CMP_WIDTH = (SUM_WIDTH > LIMIT_WIDTH) ? SUM_WIDTH : LIMIT_WIDTH;
    localparam int ROT_COMPONENTS = 4;
    localparam int IDX_WIDTH = 3;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SETUP  = 5'b00010,
        S_ROTATE = 5'b00100,
        S_SCALE  = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t                           state_reg;
    state_t                           state_next;
    cfg_t                             cfg;
    pair_t                            pair_reg;
    status_t                          status_reg;
    logic                             rotated_reg;
    logic [COUNT_WIDTH-1:0]           count_reg;
    logic [COUNT_WIDTH-1:0]           count_eff;
    logic [IDX_WIDTH-1:0]             idx_reg;
    logic [IDX_WIDTH-1:0]             idx_prev;
    logic signed [MOMENTUM_WIDTH-1:0] rot_mom_reg [ROT_COMPONENTS];
    result_t                          result_reg;
    logic                             result_valid_reg;

    logic                             pair_accept;
    logic                             limit_hit;
    logic signed [SUM_WIDTH-1:0]      axis_diff;
    logic [SUM_WIDTH-1:0]             axis_abs;
    logic [LIMIT_WIDTH-1:0]           cut_threshold;
    logic                             cut_hit;
    logic                             rotate_want;
    logic                             cordic_start;
    logic                             cordic_done;
    cordic_load_t                     cordic_load;
    cordic_vec_t                      cordic_vec;
    logic signed [CORDIC_WIDTH-1:0]   scale_operand;
    logic signed [MOMENTUM_WIDTH-1:0] scaled;
    logic                             result_load;
    result_t                          result_next;

    pmcr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pmcr_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .load  (cordic_load),
        .done  (cordic_done),
        .vec   (cordic_vec)
    );

    pmcr_scale u_scale (
        .clk     (clk),
        .operand (scale_operand),
        .scaled  (scaled)
    );

    assign pair_stall  = (state_reg != S_IDLE);
    assign pair_accept = pair_valid && !pair_stall;

    // keep limit
    assign count_eff = pair_data.new_file ? '0 : count_reg;
    assign limit_hit = cfg.limit_enable && (count_eff >= cfg.keep_limit);

    // axis cut and rotation decision
    assign axis_diff = cfg.polarization_axis
                     ? (SUM_WIDTH'(pair_reg.proton_pz) - SUM_WIDTH'(pair_reg.neutron_pz))
                     : (SUM_WIDTH'(pair_reg.proton_py) - SUM_WIDTH'(pair_reg.neutron_py));
    assign axis_abs      = axis_diff[SUM_WIDTH-1] ? -axis_diff : axis_diff;
    assign cut_threshold = cfg.polarization_axis ? cfg.z_axis_limit : cfg.y_axis_limit;
    assign cut_hit       = cfg.cut_enable && (CMP_WIDTH'(axis_abs) >= CMP_WIDTH'(cut_threshold));
    assign rotate_want = cfg.polarization_axis ? cfg.rotate_for_z : cfg.rotate_for_y;

    assign cordic_load.sum_x      = SUM_WIDTH'(pair_reg.proton_px) + SUM_WIDTH'(pair_reg.neutron_px);
    assign cordic_load.sum_y      = SUM_WIDTH'(pair_reg.proton_py) + SUM_WIDTH'(pair_reg.neutron_py);
    assign cordic_load.negate     = cordic_load.sum_x[SUM_WIDTH-1];
    assign cordic_load.proton_px  = pair_reg.proton_px;
    assign cordic_load.proton_py  = pair_reg.proton_py;
    assign cordic_load.neutron_px = pair_reg.neutron_px;
    assign cordic_load.neutron_py = pair_reg.neutron_py;

    assign cordic_start = (state_reg == S_SETUP) && (status_reg == ST_WRITTEN) && !cut_hit
                       && rotate_want
                       && ((cordic_load.sum_x != '0) || (cordic_load.sum_y != '0));

    always_comb
    begin
        case (idx_reg[1:0])
            2'd0:    scale_operand = cordic_vec.proton_px;
            2'd1:    scale_operand = cordic_vec.proton_py;
            2'd2:    scale_operand = cordic_vec.neutron_px;
            default: scale_operand = cordic_vec.neutron_py;
        endcase
    end

    assign idx_prev = idx_reg - 1'b1;

    assign result_load = (state_reg == S_DONE) && (!result_valid_reg || !result_stall);

    always_comb
    begin
        result_next.status           = status_reg;
        result_next.was_rotated      = rotated_reg;
        result_next.out_event_number = pair_reg.event_number;
        result_next.out_proton_px    = rotated_reg ? rot_mom_reg[0] : pair_reg.proton_px;
        result_next.out_proton_py    = rotated_reg ? rot_mom_reg[1] : pair_reg.proton_py;
        result_next.out_proton_pz    = pair_reg.proton_pz;
        result_next.out_neutron_px   = rotated_reg ? rot_mom_reg[2] : pair_reg.neutron_px;
        result_next.out_neutron_py   = rotated_reg ? rot_mom_reg[3] : pair_reg.neutron_py;
        result_next.out_neutron_pz   = pair_reg.neutron_pz;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pair_accept)
                    state_next = S_SETUP;
            end
            S_SETUP:
            begin
                state_next = cordic_start ? S_ROTATE : S_DONE;
            end
            S_ROTATE:
            begin
                if (cordic_done)
                    state_next = S_SCALE;
            end
            S_SCALE:
            begin
                if (idx_reg == IDX_WIDTH'(ROT_COMPONENTS))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (result_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            status_reg       <= ST_WRITTEN;
            rotated_reg      <= 1'b0;
            idx_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pair_accept)
            begin
                rotated_reg <= 1'b0;
                if (limit_hit)
                begin
                    status_reg <= ST_LIMIT;
                    count_reg  <= count_eff;
                end
                else
                begin
                    status_reg <= ST_WRITTEN;
                    count_reg  <= (count_eff == '1) ? count_eff : count_eff + 1'b1;
                end
            end
            if (state_reg == S_SETUP)
            begin
                if ((status_reg == ST_WRITTEN) && cut_hit)
                    status_reg <= ST_CUT;
                rotated_reg <= cordic_start;
            end
            if (state_reg == S_ROTATE)
                idx_reg <= '0;
            else if (state_reg == S_SCALE)
                idx_reg <= idx_reg + 1'b1;
            if (result_load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair_accept)
            pair_reg <= pair_data;
        if ((state_reg == S_SCALE) && (idx_reg != '0))
            rot_mom_reg[idx_prev[1:0]] <= scaled;
        if (result_load)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

endmodule

### hw/rtl/pmcr_checker.sv
// ---------------------------------------------------------------------------
// Pair momentum cut and rotate checker
// Port-level assertions on the event and result channels, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pmcr_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pair_valid,
    input  logic              pair_stall,
    input  logic              result_valid,
    input  logic              result_stall,
    input  pmcr_pkg::result_t result_data
);
    import pmcr_pkg::*;

    `ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && result_stall, result_valid)
    `ASSERT_NEXT(a_result_stable, clk, rst_n, result_valid && result_stall, $stable(result_data))
    `ASSERT_NEXT(a_busy_after_beat, clk, rst_n, pair_valid && !pair_stall, pair_stall)
    `ASSERT_IMPLIES(a_rotate_only_written, clk, rst_n, result_valid && result_data.was_rotated, result_data.status == ST_WRITTEN)

endmodule

bind pair_momentum_cut_and_rotate pmcr_checker u_pmcr_checker (.*);
